FILE: hw/rtl/srr_pkg.sv
// Package for the selective-repeat receive reorder block: sizes, codes and transfer types.
`default_nettype none

package srr_pkg;

    // Window and sequence sizing; both are powers of two so that slot and modulo
    // arithmetic reduce to bit selects.
    localparam int RX_WIN_SLOTS = 16;
    localparam int SEQ_SPACE    = 256;
    localparam int MAX_PAYLOAD  = 1024;

    localparam int SEQ_W = $clog2(SEQ_SPACE);
    localparam int IDX_W = (RX_WIN_SLOTS > 1) ? $clog2(RX_WIN_SLOTS) : 1;
    localparam int REF_W = 32;
    localparam int LEN_W = 11;

    // Depth of the command queue between the front and back parts.
    localparam int CMDQ_DEPTH = 2;
    localparam int CMDQ_PTR_W = $clog2(CMDQ_DEPTH);
    localparam int CMDQ_CNT_W = CMDQ_PTR_W + 1;

    // Result kinds.
    localparam logic KIND_DELIVER = 1'b0;
    localparam logic KIND_ACK     = 1'b1;

    typedef struct packed {
        logic [7:0]       seq_num;
        logic [REF_W-1:0] payload_ref;
        logic [LEN_W-1:0] payload_len;
        logic             is_data;
        logic             intact;
    } pkt_t;

    typedef struct packed {
        logic             kind;
        logic [7:0]       out_seq;
        logic [REF_W-1:0] out_ref;
        logic [LEN_W-1:0] out_len;
        logic             last;
    } result_t;

    // Classified command handed from the front part to the back part.
    typedef struct packed {
        logic [SEQ_W-1:0] seq;
        logic [REF_W-1:0] ref_val;
        logic [LEN_W-1:0] len;
    } cmd_t;

    typedef enum logic [1:0] {
        B_IDLE,
        B_CHECK,
        B_DRAIN,
        B_ACK
    } back_state_t;

endpackage

`default_nettype wire

FILE: hw/rtl/srr_front.sv
// Front part: accepts packet descriptors, drops non-data or corrupt ones, saturates length.
`default_nettype none

module srr_front (
    input  wire srr_pkg::pkt_t pkt,
    input  wire                push,
    output logic               full,
    input  wire                q_full,
    output logic               q_push,
    output srr_pkg::cmd_t      q_data
);

    logic keep;

    assign full   = q_full;
    assign keep   = pkt.intact && pkt.is_data;
    assign q_push = push && !q_full && keep;

    always_comb
    begin
        q_data.seq     = srr_pkg::SEQ_W'(pkt.seq_num);
        q_data.ref_val = pkt.payload_ref;
        if (pkt.payload_len > srr_pkg::LEN_W'(srr_pkg::MAX_PAYLOAD))
        begin
            q_data.len = srr_pkg::LEN_W'(srr_pkg::MAX_PAYLOAD);
        end
        else
        begin
            q_data.len = pkt.payload_len;
        end
    end

endmodule

`default_nettype wire

FILE: hw/rtl/srr_queue.sv
// Short command queue that decouples the front part from the back part.
`default_nettype none

module srr_queue (
    input  wire                clk,
    input  wire                rst_n,
    input  wire                wr_en,
    input  wire srr_pkg::cmd_t wr_data,
    output logic               q_full,
    input  wire                rd_en,
    output srr_pkg::cmd_t      rd_data,
    output logic               q_empty
);

    srr_pkg::cmd_t                     mem_reg [srr_pkg::CMDQ_DEPTH];
    logic [srr_pkg::CMDQ_PTR_W-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [srr_pkg::CMDQ_PTR_W-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [srr_pkg::CMDQ_CNT_W-1:0]    count_reg, count_next;
    logic                              do_wr, do_rd;

    assign q_full  = (count_reg == srr_pkg::CMDQ_CNT_W'(srr_pkg::CMDQ_DEPTH));
    assign q_empty = (count_reg == '0);
    assign do_wr   = wr_en && !q_full;
    assign do_rd   = rd_en && !q_empty;
    assign rd_data = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = do_wr ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_rd ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr && !do_rd)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_rd && !do_wr)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

`default_nettype wire

FILE: hw/rtl/srr_back.sv
// Back part: window test, slot store, in-order drain and acknowledgement generation.
`default_nettype none

module srr_back (
    input  wire                clk,
    input  wire                rst_n,
    input  wire                q_empty,
    input  wire srr_pkg::cmd_t q_data,
    output logic               q_pop,
    output srr_pkg::result_t   result,
    output logic               empty,
    input  wire                pop
);

    srr_pkg::back_state_t         state_reg, state_next;
    srr_pkg::cmd_t                cmd_reg;
    logic [srr_pkg::SEQ_W-1:0]    base_reg;
    logic [srr_pkg::RX_WIN_SLOTS-1:0] filled_reg;
    logic [srr_pkg::REF_W-1:0]    slot_ref_reg [srr_pkg::RX_WIN_SLOTS];
    logic [srr_pkg::LEN_W-1:0]    slot_len_reg [srr_pkg::RX_WIN_SLOTS];
    logic [srr_pkg::SEQ_W-1:0]    slot_seq_reg [srr_pkg::RX_WIN_SLOTS];
    srr_pkg::result_t             out_reg, out_next;
    logic                         out_valid_reg;

    logic [srr_pkg::SEQ_W-1:0]    seq_offset;
    logic                         in_win;
    logic [srr_pkg::IDX_W-1:0]    wr_idx, head_idx;
    logic                         head_filled;
    logic                         out_free;
    logic                         store_en, load_deliver, load_ack;

    assign seq_offset  = cmd_reg.seq - base_reg;
    assign in_win      = (seq_offset < srr_pkg::SEQ_W'(srr_pkg::RX_WIN_SLOTS));
    assign wr_idx      = cmd_reg.seq[srr_pkg::IDX_W-1:0];
    assign head_idx    = base_reg[srr_pkg::IDX_W-1:0];
    assign head_filled = filled_reg[head_idx];
    assign out_free    = !out_valid_reg || pop;
    assign result      = out_reg;
    assign empty       = !out_valid_reg;

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            srr_pkg::B_IDLE:
            begin
                if (!q_empty)
                begin
                    state_next = srr_pkg::B_CHECK;
                end
            end
            srr_pkg::B_CHECK:
            begin
                state_next = in_win ? srr_pkg::B_DRAIN : srr_pkg::B_ACK;
            end
            srr_pkg::B_DRAIN:
            begin
                if (!head_filled)
                begin
                    state_next = srr_pkg::B_ACK;
                end
            end
            srr_pkg::B_ACK:
            begin
                if (out_free)
                begin
                    state_next = srr_pkg::B_IDLE;
                end
            end
            default:
            begin
                state_next = srr_pkg::B_IDLE;
            end
        endcase
    end

    // Control outputs.
    always_comb
    begin
        q_pop        = 1'b0;
        store_en     = 1'b0;
        load_deliver = 1'b0;
        load_ack     = 1'b0;
        case (state_reg)
            srr_pkg::B_IDLE:  q_pop        = !q_empty;
            srr_pkg::B_CHECK: store_en     = in_win && !filled_reg[wr_idx];
            srr_pkg::B_DRAIN: load_deliver = head_filled && out_free;
            srr_pkg::B_ACK:   load_ack     = out_free;
            default:
            begin
                q_pop = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        out_next = out_reg;
        if (load_deliver)
        begin
            out_next.kind    = srr_pkg::KIND_DELIVER;
            out_next.out_seq = 8'(slot_seq_reg[head_idx]);
            out_next.out_ref = slot_ref_reg[head_idx];
            out_next.out_len = slot_len_reg[head_idx];
            out_next.last    = 1'b0;
        end
        else if (load_ack)
        begin
            out_next.kind    = srr_pkg::KIND_ACK;
            out_next.out_seq = 8'(cmd_reg.seq);
            out_next.out_ref = '0;
            out_next.out_len = '0;
            out_next.last    = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= srr_pkg::B_IDLE;
            base_reg      <= '0;
            filled_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (store_en)
            begin
                filled_reg[wr_idx] <= 1'b1;
            end
            else if (load_deliver)
            begin
                filled_reg[head_idx] <= 1'b0;
            end
            if (load_deliver)
            begin
                base_reg <= base_reg + srr_pkg::SEQ_W'(1);
            end
            if (load_deliver || load_ack)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (pop)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            cmd_reg <= q_data;
        end
        if (store_en)
        begin
            slot_ref_reg[wr_idx] <= cmd_reg.ref_val;
            slot_len_reg[wr_idx] <= cmd_reg.len;
            slot_seq_reg[wr_idx] <= cmd_reg.seq;
        end
        out_reg <= out_next;
    end

    // The window base moves only while draining.
    a_base_only_in_drain: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != srr_pkg::B_DRAIN) |=> $stable(base_reg))
        else $error("window base moved outside the drain phase");

    // A stored descriptor leaves its slot marked as filled.
    a_store_sets_flag: assert property (@(posedge clk) disable iff (!rst_n)
        store_en |=> filled_reg[$past(wr_idx)])
        else $error("slot flag not set after a store");

    // An acknowledgement always closes the result sequence.
    a_ack_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        load_ack |=> (out_valid_reg && out_reg.last && (out_reg.kind == srr_pkg::KIND_ACK)))
        else $error("acknowledgement not presented as the last result");

    // A new result is never loaded over one that has not been taken.
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !pop) |-> !(load_deliver || load_ack))
        else $error("pending result overwritten");

endmodule

`default_nettype wire

FILE: hw/rtl/selective_repeat_receive_reorder.sv
// Top level of the selective-repeat receive reorder block.
// Order: a transfer in to an idle back part is queued, popped into the command register and
// checked; n deliveries (n at most 16) follow from the drain and then the ack; a packet outside
// the window is acked straight after the check. The back part takes one packet at a time, its
// drain emitting one result per cycle while results are popped; dropped packets skip the queue.
// Reset: asynchronous, active low; empties queue and output, zeroes the base, clears the slot flags.
`default_nettype none

module selective_repeat_receive_reorder (
    input  wire                   clk,
    input  wire                   rst_n,
    input  wire srr_pkg::pkt_t    pkt,
    input  wire                   push,
    output logic                  full,
    output srr_pkg::result_t      result,
    output logic                  empty,
    input  wire                   pop
);

    // The front part classifies each transfer in: a corrupt or non-data packet is
    // accepted and discarded on the spot, while an intact data packet has its length
    // saturated and is written to the command queue.
    logic          q_push;
    logic          q_full;
    srr_pkg::cmd_t q_wr_data;

    // The back part pops commands one at a time and runs its sequencer over the
    // receive window; it owns the window base, the slot flags and the slot stores.
    logic          q_pop;
    logic          q_empty;
    srr_pkg::cmd_t q_rd_data;

    srr_front u_front (
        .pkt    (pkt),
        .push   (push),
        .full   (full),
        .q_full (q_full),
        .q_push (q_push),
        .q_data (q_wr_data)
    );

    // The queue lets new packets be taken in while the back part is still draining
    // the window for an earlier one.
    srr_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (q_push),
        .wr_data (q_wr_data),
        .q_full  (q_full),
        .rd_en   (q_pop),
        .rd_data (q_rd_data),
        .q_empty (q_empty)
    );

    // Results leave through an output register in the back part, so a result that
    // waits for its transfer out stalls the sequencer first, and the input side only
    // once the command queue has filled up behind it.
    srr_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_empty (q_empty),
        .q_data  (q_rd_data),
        .q_pop   (q_pop),
        .result  (result),
        .empty   (empty),
        .pop     (pop)
    );

endmodule

`default_nettype wire
